[rtl/core/lfct_pkg.sv]
// shared constants for the lru frame cache tracker
`default_nettype none

package lfct_pkg;

   localparam int LFCT_SLOTS       = 32;
   localparam int LFCT_FRAME_W     = 16;
   localparam int LFCT_LIMIT_W     = 6;
   localparam int LFCT_SLOT_W      = 5;
   localparam int LFCT_REQ_DATA_W  = 16;
   localparam int LFCT_RSP_DATA_W  = 24;

   localparam logic [LFCT_LIMIT_W-1:0] LFCT_LIMIT_RESET = 6'd32;

endpackage

`default_nettype wire

[rtl/core/lfct_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none

module lfct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/core/lru_frame_cache_tracker_unit.sv]
// lru frame cache tracker: fully associative residency tracking with lru replacement
//
//   channel  dir  fields (low bit first)
//   req      in   tdata: frame_number[15:0]
//   rsp      out  tdata: hit[0], slot[5:1], evicted[6], evicted_frame[22:7], zero pad
//   csr      in   wr_en / wr_data: resident_limit[5:0]
//
// each request, from accept until req_tready returns, runs through two passes:
// a lookup pass and a rank aging pass, each a serial scan of the frame and rank
// memories through their single read port, one slot per cycle
// reset clears the valid bits, the resident count and the limit (to 32)
// a finished result waits in the output register; a new request is taken meanwhile,
// and the next result waits until the previous one has been taken
`default_nettype none

module lru_frame_cache_tracker_unit
   import lfct_pkg::*;
#(
   parameter int SLOTS = LFCT_SLOTS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [LFCT_REQ_DATA_W-1:0] req_tdata,  // frame_number
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [LFCT_RSP_DATA_W-1:0] rsp_tdata,  // hit, slot, evicted, evicted_frame
   input  wire logic                       csr_wr_en,
   input  wire logic [LFCT_LIMIT_W-1:0]    csr_wr_data
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int LW = (CW > LFCT_LIMIT_W) ? CW : LFCT_LIMIT_W;
   localparam int XW = (IW > LFCT_SLOT_W) ? IW : LFCT_SLOT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_AGE,
      ST_FINISH
   } state_type;

   state_type                state_ff;
   logic [LFCT_LIMIT_W-1:0]  limit_ff;
   logic [SLOTS-1:0]         valid_ff;
   logic [CW-1:0]            count_ff;
   logic [LFCT_FRAME_W-1:0]  frame_ff;
   logic [IW-1:0]            idx_ff;
   logic                     scan_on_ff;
   logic                     stage_vld_ff;
   logic [IW-1:0]            stage_idx_ff;
   logic                     hit_found_ff;
   logic [IW-1:0]            hit_idx_ff;
   logic [IW-1:0]            hit_rank_ff;
   logic                     free_found_ff;
   logic [IW-1:0]            free_idx_ff;
   logic [IW-1:0]            victim_idx_ff;
   logic [LFCT_FRAME_W-1:0]  victim_frame_ff;
   logic [IW-1:0]            target_ff;
   logic                     evict_ff;
   logic                     rsp_valid_ff;
   logic [LFCT_RSP_DATA_W-1:0] rsp_data_ff;

   logic [LFCT_FRAME_W-1:0]  frame_rd;
   logic [IW-1:0]            rank_rd;
   logic                     frame_we;
   logic                     rank_we;
   logic [IW-1:0]            rank_wdata;
   logic [IW-1:0]            target_in;
   logic                     evict_in;
   logic [LW-1:0]            limit_ext;
   logic [LW-1:0]            slots_ext;
   logic [LW-1:0]            eff_limit;
   logic                     have_room;
   logic [CW-1:0]            count_m1_wide;
   logic [IW-1:0]            count_m1;
   logic                     stage_valid;
   logic                     stage_is_last;
   logic [XW-1:0]            slot_wide;

   lfct_ram #(
      .WIDTH (LFCT_FRAME_W),
      .DEPTH (SLOTS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (target_in),
      .wr_data (frame_ff),
      .rd_addr (idx_ff),
      .rd_data (frame_rd)
   );

   lfct_ram #(
      .WIDTH (IW),
      .DEPTH (SLOTS)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (stage_idx_ff),
      .wr_data (rank_wdata),
      .rd_addr (idx_ff),
      .rd_data (rank_rd)
   );

   // effective limit clamped to 1..SLOTS
   always_comb begin
      limit_ext = LW'(limit_ff);
      slots_ext = LW'(SLOTS);
      if (limit_ext == '0) begin
         eff_limit = LW'(1);
      end else if (limit_ext > slots_ext) begin
         eff_limit = slots_ext;
      end else begin
         eff_limit = limit_ext;
      end
      have_room = LW'(count_ff) < eff_limit;
   end

   assign count_m1_wide = count_ff - CW'(1);
   assign count_m1      = count_m1_wide[IW-1:0];
   assign stage_valid   = valid_ff[stage_idx_ff];
   assign stage_is_last = stage_idx_ff == LAST_IDX;

   always_comb begin
      if (hit_found_ff) begin
         target_in = hit_idx_ff;
         evict_in  = 1'b0;
      end else if (have_room) begin
         target_in = free_idx_ff;
         evict_in  = 1'b0;
      end else begin
         target_in = victim_idx_ff;
         evict_in  = 1'b1;
      end
   end

   assign frame_we = (state_ff == ST_DECIDE) && !hit_found_ff;

   // aging: target goes to rank 0, others below the hit rank (all on a miss) move up
   always_comb begin
      rank_we    = 1'b0;
      rank_wdata = rank_rd + IW'(1);
      if (state_ff == ST_AGE && stage_vld_ff) begin
         if (stage_idx_ff == target_ff) begin
            rank_we    = 1'b1;
            rank_wdata = '0;
         end else if (stage_valid && (!hit_found_ff || rank_rd < hit_rank_ff)) begin
            rank_we = 1'b1;
         end
      end
   end

   assign slot_wide  = XW'(target_ff);
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= LFCT_LIMIT_RESET;
         valid_ff      <= '0;
         count_ff      <= '0;
         scan_on_ff    <= 1'b0;
         stage_vld_ff  <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         // shared scan sequencer
         if (scan_on_ff) begin
            stage_vld_ff <= 1'b1;
            stage_idx_ff <= idx_ff;
            idx_ff       <= idx_ff + IW'(1);
            if (idx_ff == LAST_IDX) begin
               scan_on_ff <= 1'b0;
            end
         end else begin
            stage_vld_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  frame_ff      <= req_tdata[LFCT_FRAME_W-1:0];
                  idx_ff        <= '0;
                  scan_on_ff    <= 1'b1;
                  hit_found_ff  <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (stage_vld_ff) begin
                  if (stage_valid && frame_rd == frame_ff && !hit_found_ff) begin
                     hit_found_ff <= 1'b1;
                     hit_idx_ff   <= stage_idx_ff;
                     hit_rank_ff  <= rank_rd;
                  end
                  if (!stage_valid && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= stage_idx_ff;
                  end
                  // ranks of valid entries are distinct, so the oldest has count-1
                  if (stage_valid && rank_rd == count_m1) begin
                     victim_idx_ff   <= stage_idx_ff;
                     victim_frame_ff <= frame_rd;
                  end
                  if (stage_is_last) begin
                     state_ff <= ST_DECIDE;
                  end
               end
            end
            ST_DECIDE: begin
               target_ff <= target_in;
               evict_ff  <= evict_in;
               if (!hit_found_ff) begin
                  valid_ff[target_in] <= 1'b1;
                  if (!evict_in) begin
                     count_ff <= count_ff + CW'(1);
                  end
               end
               idx_ff       <= '0;
               scan_on_ff   <= 1'b1;
               state_ff     <= ST_AGE;
            end
            ST_AGE: begin
               if (stage_vld_ff && stage_is_last) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {1'b0,
                                   (evict_ff ? victim_frame_ff : LFCT_FRAME_W'(0)),
                                   evict_ff,
                                   slot_wide[LFCT_SLOT_W-1:0],
                                   hit_found_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
